// ----- rtl/core/fsa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-slot allocator package
// Shared constants, beat layouts, command codes and controller states.
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_BYTES = 256;

  localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);
  localparam int SIZE_W     = $clog2(SLOT_BYTES + 1);
  localparam int BLOCKS_W   = $clog2(SLOT_COUNT + 1);
  localparam int BYTES_W    = $clog2(SLOT_COUNT * SLOT_BYTES + 1);

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 168;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_END   = 2'd1,
    CMD_ALLOC = 2'd2,
    CMD_FREE  = 2'd3
  } cmd_t;

  // Packed structs list the highest bits first.
  typedef struct packed {
    logic [5:0]  pad;
    logic [7:0]  slot_to_free;
    logic [15:0] request_size;
    cmd_t        command;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  pad;
    logic        session_active;
    logic [31:0] release_count;
    logic [31:0] success_count;
    logic [31:0] call_count;
    logic [22:0] peak_byte_count;
    logic [6:0]  peak_block_count;
    logic [22:0] live_byte_count;
    logic [6:0]  live_block_count;
    logic [7:0]  granted_slot;
    logic        ok;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic exec;
  } dp_cmd_t;

  typedef enum logic {
    ST_EMPTY,
    ST_HELD
  } fsa_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/fsa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-slot allocator controller
// Sequences capture of an input beat, its execution and the output handshake.
// ----------------------------------------------------------------------------
module fsa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output fsa_pkg::dp_cmd_t     dp_cmd
);
  import fsa_pkg::*;

  fsa_state_t state;
  fsa_state_t state_next;
  logic       out_valid;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_EMPTY;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    dp_cmd.load_in = 1'b0;
    dp_cmd.exec    = 1'b0;
    unique case (state)
      ST_EMPTY: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          dp_cmd.load_in = 1'b1;
          state_next     = ST_HELD;
        end
      end
      ST_HELD: begin
        // Execute only when the output register is free or is being drained.
        if (!out_valid || m_tready) begin
          dp_cmd.exec = 1'b1;
          state_next  = ST_EMPTY;
        end
      end
      default: state_next = ST_EMPTY;
    endcase

    if (dp_cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_tvalid = out_valid;

endmodule
`default_nettype wire

// ----- rtl/core/fsa_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-slot allocator datapath
// Slot map, slot sizes, session counters and the result register.
// ----------------------------------------------------------------------------
module fsa_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fsa_pkg::dp_cmd_t   dp_cmd,
  input  wire fsa_pkg::in_item_t  in_item,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata,
  output fsa_pkg::out_item_t      out_item
);
  import fsa_pkg::*;

  in_item_t              in_q;
  logic [31:0]           forced_call;
  logic [SLOT_COUNT-1:0] slot_in_use;
  logic [SIZE_W-1:0]     slot_size [SLOT_COUNT];
  logic                  active;
  logic [BLOCKS_W-1:0]   blocks_live;
  logic [BYTES_W-1:0]    bytes_live;
  logic [BLOCKS_W-1:0]   blocks_peak;
  logic [BYTES_W-1:0]    bytes_peak;
  logic [31:0]           calls_seen;
  logic [31:0]           grants_seen;
  logic [31:0]           releases_seen;
  logic                  result_ok;
  logic [7:0]            result_slot;

  logic                  free_found;
  logic [SLOT_IDX_W-1:0] free_idx;
  logic [SLOT_IDX_W-1:0] victim_idx;
  logic                  victim_ok;
  logic [31:0]           calls_inc;
  logic                  alloc_ok;
  logic                  inject_fail;
  logic [BLOCKS_W-1:0]   blocks_inc;
  logic [BYTES_W-1:0]    bytes_inc;

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_in_use[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_IDX_W'(i);
      end
    end
  end

  assign victim_idx  = in_q.slot_to_free[SLOT_IDX_W-1:0];
  assign victim_ok   = active && (in_q.slot_to_free < 8'(SLOT_COUNT))
                       && slot_in_use[victim_idx];
  assign alloc_ok    = active && (in_q.request_size <= 16'(SLOT_BYTES));
  assign calls_inc   = calls_seen + 32'd1;
  assign inject_fail = (forced_call != 32'd0) && (calls_inc == forced_call);
  assign blocks_inc  = blocks_live + BLOCKS_W'(1);
  assign bytes_inc   = bytes_live + BYTES_W'(in_q.request_size[SIZE_W-1:0]);

  always_ff @(posedge clk) begin
    if (dp_cmd.load_in) begin
      in_q <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec && in_q.command == CMD_ALLOC && alloc_ok && !inject_fail
        && free_found) begin
      slot_size[free_idx] <= in_q.request_size[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      forced_call   <= '0;
      slot_in_use   <= '0;
      active        <= 1'b0;
      blocks_live   <= '0;
      bytes_live    <= '0;
      blocks_peak   <= '0;
      bytes_peak    <= '0;
      calls_seen    <= '0;
      grants_seen   <= '0;
      releases_seen <= '0;
    end else begin
      if (cfg_we) begin
        forced_call <= cfg_wdata;
      end
      if (dp_cmd.exec) begin
        unique case (in_q.command)
          CMD_BEGIN: begin
            if (!active) begin
              slot_in_use   <= '0;
              blocks_live   <= '0;
              bytes_live    <= '0;
              blocks_peak   <= '0;
              bytes_peak    <= '0;
              calls_seen    <= '0;
              grants_seen   <= '0;
              releases_seen <= '0;
              active        <= 1'b1;
            end
          end
          CMD_END: begin
            // With no live block the slot map and live totals are already clear.
            if (active && blocks_live == '0) begin
              active <= 1'b0;
            end
          end
          CMD_ALLOC: begin
            if (alloc_ok) begin
              calls_seen <= calls_inc;
              if (!inject_fail && free_found) begin
                slot_in_use[free_idx] <= 1'b1;
                grants_seen           <= grants_seen + 32'd1;
                blocks_live           <= blocks_inc;
                bytes_live            <= bytes_inc;
                if (blocks_inc > blocks_peak) begin
                  blocks_peak <= blocks_inc;
                end
                if (bytes_inc > bytes_peak) begin
                  bytes_peak <= bytes_inc;
                end
              end
            end
          end
          CMD_FREE: begin
            if (victim_ok) begin
              slot_in_use[victim_idx] <= 1'b0;
              blocks_live             <= blocks_live - BLOCKS_W'(1);
              bytes_live              <= bytes_live - BYTES_W'(slot_size[victim_idx]);
              releases_seen           <= releases_seen + 32'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Status fields follow the state registers; ok and the grant are captured.
  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      result_slot <= '0;
      unique case (in_q.command)
        CMD_BEGIN: result_ok <= !active;
        CMD_END:   result_ok <= active && (blocks_live == '0);
        CMD_ALLOC: begin
          result_ok <= alloc_ok && !inject_fail && free_found;
          if (alloc_ok && !inject_fail && free_found) begin
            result_slot <= 8'(free_idx);
          end
        end
        CMD_FREE:  result_ok <= victim_ok;
        default:   result_ok <= 1'b0;
      endcase
    end
  end

  assign out_item.pad              = '0;
  assign out_item.ok               = result_ok;
  assign out_item.granted_slot     = result_slot;
  assign out_item.session_active   = active;
  assign out_item.release_count    = releases_seen;
  assign out_item.success_count    = grants_seen;
  assign out_item.call_count       = calls_seen;
  assign out_item.peak_byte_count  = 23'(bytes_peak);
  assign out_item.peak_block_count = 7'(blocks_peak);
  assign out_item.live_byte_count  = 23'(bytes_live);
  assign out_item.live_block_count = 7'(blocks_live);

`ifndef NO_ASSERTIONS
  a_live_matches_map: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_in_use) == 32'(blocks_live))
    else $error("live block count differs from slot map");

  a_block_peak: assert property (@(posedge clk) disable iff (rst)
    blocks_peak >= blocks_live)
    else $error("block peak below live count");

  a_byte_peak: assert property (@(posedge clk) disable iff (rst)
    bytes_peak >= bytes_live)
    else $error("byte peak below live bytes");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !active |-> (slot_in_use == '0 && bytes_live == '0))
    else $error("slots live outside a session");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/fixed_slot_allocator_accounting.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-slot allocator with session accounting
// Begin, end, allocate and free commands over 16 slots of 256 bytes each.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive as beats on the s_ channel; each produces exactly one
//   result beat on the m_ channel carrying ok, the granted slot and all
//   session counters as they stand after the command.
//   A beat is captured in an input register at the edge it is accepted and
//   executed once the output register is free or being drained, which is
//   when m_tvalid rises. Each item is captured, then executed to update the
//   slot map and counters; s_tready is high again right after execution.
//   The result sits in an output register; a new beat is accepted while it
//   waits, but is executed only once that result is taken, so a stalled
//   receiver holds the pipeline without losing or repeating any beat.
//   cfg_we writes the forced-failure call number (zero disables it).
//   Reset (rst, synchronous) closes the session, clears the slot map, all
//   counters and the failure number, and empties both channel registers.
// ----------------------------------------------------------------------------
module fixed_slot_allocator_accounting (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // command[1:0], request_size[17:2], slot_to_free[25:18], zero pad
  input  wire logic [fsa_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // ok[0], granted_slot[8:1], live_block_count[15:9], live_byte_count[38:16],
  // peak_block_count[45:39], peak_byte_count[68:46], call_count[100:69],
  // success_count[132:101], release_count[164:133], session_active[165], pad
  output logic [fsa_pkg::OUT_DATA_W-1:0]        m_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [31:0]                      cfg_wdata
);
  import fsa_pkg::*;

  dp_cmd_t   dp_cmd;
  in_item_t  in_item;
  out_item_t out_item;

  assign in_item = in_item_t'(s_tdata);
  assign m_tdata = OUT_DATA_W'(out_item);

  fsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .dp_cmd   (dp_cmd)
  );

  fsa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .dp_cmd    (dp_cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
